// ===== hw/rtl/indexed_min_heap_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_core_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IMHQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imhq assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define IMHQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imhq assertion failed");

`endif

// ===== hw/rtl/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg
// shared sizes, codes, entry types and the heap ordering function
// ----------------------------------------------------------------------------
package imhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ID_COUNT = 1024;
    localparam int KEY_W    = 32;
    localparam int ID_W     = $clog2(ID_COUNT);
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = SLOT_W + 2;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_PEEK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ID    = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } stat_t;

    // datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LAUNCH,
        CMD_REJECT,
        CMD_PUSH,
        CMD_PEEK,
        CMD_POP,
        CMD_POP_LAST,
        CMD_UPD_READ,
        CMD_UPD,
        CMD_UP_READ,
        CMD_UP_MOVE,
        CMD_DN_READ_L,
        CMD_DN_READ_R,
        CMD_DN_MOVE,
        CMD_PLACE
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic              present;
        logic [SLOT_W-1:0] slot;
    } map_t;

    // status flags from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic reject;
        op_t  op;
        logic last_zero;
        logic key_less;
        logic key_greater;
        logic at_root;
        logic no_left;
        logic up_move;
        logic dn_move;
    } dp_stat_t;

    // lower key first, smaller id breaks a tie
    function automatic logic comes_first(entry_t a, entry_t b);
        logic lt;
        lt = ($signed(a.key) < $signed(b.key)) ||
             ((a.key == b.key) && (a.id < b.id));
        return lt;
    endfunction

endpackage

// ===== hw/rtl/imhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// imhq_ctrl
// request sequencer: clearing pass, lookup, sift up / sift down, result strobe
// ----------------------------------------------------------------------------
module imhq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output imhq_pkg::cmd_t    cmd,
    input  imhq_pkg::dp_stat_t stat
);
    import imhq_pkg::*;

    typedef enum logic [11:0] {
        ST_CLEAR   = 12'b0000_0000_0001,
        ST_IDLE    = 12'b0000_0000_0010,
        ST_LOOK    = 12'b0000_0000_0100,
        ST_POPLAST = 12'b0000_0000_1000,
        ST_UPD     = 12'b0000_0001_0000,
        ST_UP_RD   = 12'b0000_0010_0000,
        ST_UP_CMP  = 12'b0000_0100_0000,
        ST_DN_L    = 12'b0000_1000_0000,
        ST_DN_R    = 12'b0001_0000_0000,
        ST_DN_CMP  = 12'b0010_0000_0000,
        ST_PLACE   = 12'b0100_0000_0000,
        ST_DONE    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LAUNCH;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (stat.reject)
                begin
                    cmd        = CMD_REJECT;
                    state_next = ST_DONE;
                end
                else
                begin
                    case (stat.op)
                        OP_PUSH:
                        begin
                            cmd        = CMD_PUSH;
                            state_next = ST_UP_RD;
                        end
                        OP_PEEK:
                        begin
                            cmd        = CMD_PEEK;
                            state_next = ST_DONE;
                        end
                        OP_POP:
                        begin
                            cmd        = CMD_POP;
                            state_next = stat.last_zero ? ST_DONE : ST_POPLAST;
                        end
                        default:
                        begin
                            cmd        = CMD_UPD_READ;
                            state_next = ST_UPD;
                        end
                    endcase
                end
            end
            ST_POPLAST:
            begin
                cmd        = CMD_POP_LAST;
                state_next = ST_DN_L;
            end
            ST_UPD:
            begin
                cmd = CMD_UPD;
                if (stat.key_less)
                begin
                    state_next = ST_UP_RD;
                end
                else if (stat.key_greater)
                begin
                    state_next = ST_DN_L;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_UP_RD:
            begin
                if (stat.at_root)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    cmd        = CMD_UP_READ;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (stat.up_move)
                begin
                    cmd        = CMD_UP_MOVE;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_DN_L:
            begin
                if (stat.no_left)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    cmd        = CMD_DN_READ_L;
                    state_next = ST_DN_R;
                end
            end
            ST_DN_R:
            begin
                cmd        = CMD_DN_READ_R;
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (stat.dn_move)
                begin
                    cmd        = CMD_DN_MOVE;
                    state_next = ST_DN_L;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                cmd        = CMD_PLACE;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

// ===== hw/rtl/imhq_datapath.sv =====
// ----------------------------------------------------------------------------
// imhq_datapath
// heap memory, id-to-slot map memory, moving entry and result registers
// ----------------------------------------------------------------------------
module imhq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imhq_pkg::cmd_t                cmd,
    output imhq_pkg::dp_stat_t            stat,
    input  logic [1:0]                    op,
    input  logic [imhq_pkg::ID_W-1:0]     item_id,
    input  logic signed [imhq_pkg::KEY_W-1:0] key,
    output logic [1:0]                    status,
    output logic [imhq_pkg::ID_W-1:0]     out_id,
    output logic signed [imhq_pkg::KEY_W-1:0] out_key,
    output logic [imhq_pkg::CNT_W-1:0]    fill_count
);
    import imhq_pkg::*;

    // memories
    entry_t heap_mem [CAPACITY];
    map_t   map_mem  [ID_COUNT];

    entry_t            hrd_reg;
    map_t              mrd_reg;
    logic [SLOT_W-1:0] hraddr;
    logic              hwe;
    logic [SLOT_W-1:0] hwaddr;
    entry_t            hwdata;
    logic              mwe;
    logic [ID_W-1:0]   mwaddr;
    map_t              mwdata;

    // request and working registers
    op_t                  op_reg;
    logic [ID_W-1:0]      id_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ID_W-1:0]      clr_reg, clr_next;
    logic [SLOT_W-1:0]    pos_reg;
    entry_t               mv_reg;
    entry_t               cand_reg;
    stat_t                status_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic signed [KEY_W-1:0] out_key_reg;

    // tree addressing
    logic [SLOT_W-1:0] parent_idx;
    logic [IDX_W-1:0]  left_idx;
    logic [IDX_W-1:0]  right_idx;
    logic [IDX_W-1:0]  cnt_ext;
    logic              right_ok;
    entry_t            best;
    logic [SLOT_W-1:0] best_idx;
    entry_t            new_entry;
    stat_t             reject_code;
    logic              reject;

    assign parent_idx = (pos_reg - SLOT_W'(1)) >> 1;
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IDX_W'(1);
    assign cnt_ext    = IDX_W'(cnt_reg);
    assign right_ok   = right_idx < cnt_ext;
    assign new_entry  = '{id: id_reg, key: key_reg};

    // better child of the left and right children read for the sift down
    always_comb
    begin
        if (right_ok && comes_first(hrd_reg, cand_reg))
        begin
            best     = hrd_reg;
            best_idx = right_idx[SLOT_W-1:0];
        end
        else
        begin
            best     = cand_reg;
            best_idx = left_idx[SLOT_W-1:0];
        end
    end

    // lookup checks
    always_comb
    begin
        reject      = 1'b0;
        reject_code = STAT_OK;
        case (op_reg)
            OP_PUSH:
            begin
                if (mrd_reg.present)
                begin
                    reject      = 1'b1;
                    reject_code = STAT_ID;
                end
                else if (cnt_reg == CNT_W'(CAPACITY))
                begin
                    reject      = 1'b1;
                    reject_code = STAT_FULL;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (cnt_reg == '0)
                begin
                    reject      = 1'b1;
                    reject_code = STAT_EMPTY;
                end
            end
            default:
            begin
                if (!mrd_reg.present)
                begin
                    reject      = 1'b1;
                    reject_code = STAT_ID;
                end
            end
        endcase
    end

    // status to controller
    always_comb
    begin
        stat.clear_done  = (clr_reg == ID_W'(ID_COUNT - 1));
        stat.reject      = reject;
        stat.op          = op_reg;
        stat.last_zero   = (cnt_reg == CNT_W'(1));
        stat.key_less    = $signed(key_reg) < $signed(hrd_reg.key);
        stat.key_greater = $signed(hrd_reg.key) < $signed(key_reg);
        stat.at_root     = (pos_reg == '0);
        stat.no_left     = (left_idx >= cnt_ext);
        stat.up_move     = comes_first(mv_reg, hrd_reg);
        stat.dn_move     = comes_first(best, mv_reg);
    end

    // memory port selection
    always_comb
    begin
        hraddr = '0;
        hwe    = 1'b0;
        hwaddr = pos_reg;
        hwdata = mv_reg;
        mwe    = 1'b0;
        mwaddr = mv_reg.id;
        mwdata = '{present: 1'b1, slot: pos_reg};
        case (cmd)
            CMD_CLEAR:
            begin
                mwe    = 1'b1;
                mwaddr = clr_reg;
                mwdata = '0;
            end
            CMD_POP:
            begin
                hraddr = SLOT_W'(cnt_reg - CNT_W'(1));
                mwe    = 1'b1;
                mwaddr = hrd_reg.id;
                mwdata = '0;
            end
            CMD_UPD_READ:
            begin
                hraddr = mrd_reg.slot;
            end
            CMD_UP_READ:
            begin
                hraddr = parent_idx;
            end
            CMD_UP_MOVE:
            begin
                hwe    = 1'b1;
                hwdata = hrd_reg;
                mwe    = 1'b1;
                mwaddr = hrd_reg.id;
            end
            CMD_DN_READ_L:
            begin
                hraddr = left_idx[SLOT_W-1:0];
            end
            CMD_DN_READ_R:
            begin
                hraddr = right_idx[SLOT_W-1:0];
            end
            CMD_DN_MOVE:
            begin
                hwe    = 1'b1;
                hwdata = best;
                mwe    = 1'b1;
                mwaddr = best.id;
            end
            CMD_PLACE:
            begin
                hwe = 1'b1;
                mwe = 1'b1;
            end
            default:
            begin
                hraddr = '0;
            end
        endcase
    end

    // heap memory
    always_ff @(posedge clk)
    begin
        if (hwe)
        begin
            heap_mem[hwaddr] <= hwdata;
        end
        hrd_reg <= heap_mem[hraddr];
    end

    // id map memory, read at the incoming id
    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            map_mem[mwaddr] <= mwdata;
        end
        mrd_reg <= map_mem[item_id];
    end

    // entry count and clearing counter
    always_comb
    begin
        cnt_next = cnt_reg;
        clr_next = clr_reg;
        case (cmd)
            CMD_CLEAR: clr_next = clr_reg + ID_W'(1);
            CMD_PUSH:  cnt_next = cnt_reg + CNT_W'(1);
            CMD_POP:   cnt_next = cnt_reg - CNT_W'(1);
            default:   cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            clr_reg <= clr_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LAUNCH:
            begin
                op_reg      <= op_t'(op);
                id_reg      <= item_id;
                key_reg     <= key;
                status_reg  <= STAT_OK;
                out_id_reg  <= '0;
                out_key_reg <= '0;
            end
            CMD_REJECT:
            begin
                status_reg <= reject_code;
            end
            CMD_PUSH:
            begin
                mv_reg  <= new_entry;
                pos_reg <= SLOT_W'(cnt_reg);
            end
            CMD_PEEK:
            begin
                out_id_reg  <= hrd_reg.id;
                out_key_reg <= hrd_reg.key;
            end
            CMD_POP:
            begin
                out_id_reg  <= hrd_reg.id;
                out_key_reg <= hrd_reg.key;
                pos_reg     <= '0;
            end
            CMD_POP_LAST:
            begin
                mv_reg <= hrd_reg;
            end
            CMD_UPD_READ:
            begin
                pos_reg <= mrd_reg.slot;
            end
            CMD_UPD:
            begin
                mv_reg <= new_entry;
            end
            CMD_UP_MOVE:
            begin
                pos_reg <= parent_idx;
            end
            CMD_DN_READ_R:
            begin
                cand_reg <= hrd_reg;
            end
            CMD_DN_MOVE:
            begin
                pos_reg <= best_idx;
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    assign status     = status_reg;
    assign out_id     = out_id_reg;
    assign out_key    = out_key_reg;
    assign fill_count = cnt_reg;

endmodule

// ===== hw/rtl/indexed_min_heap_queue_core.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_core
// indexed binary min-heap of (id, priority) with push, pop, update and peek
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// status, out_id, out_key and fill_count for the single cycle in which done is
// high, and must be taken then, as the receiver cannot stall. One request is
// in flight at a time, and the next request can be taken in the cycle after
// done. Rejected requests, peek, a pop of the last entry and an update that
// keeps its key go from the lookup to done with no sift; push and an update
// that lowers the key sift up, and pop and an update that raises the key sift
// down. The sift walk is paced by the single read port of the heap memory,
// which it uses once per parent or child.
// After reset, busy stays high while the id map is cleared.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic [imhq_pkg::ID_W-1:0]         item_id,
    input  logic signed [imhq_pkg::KEY_W-1:0] key,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [imhq_pkg::ID_W-1:0]         out_id,
    output logic signed [imhq_pkg::KEY_W-1:0] out_key,
    output logic [imhq_pkg::CNT_W-1:0]        fill_count
);
    import imhq_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    // sequencer
    imhq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // storage and datapath
    imhq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op),
        .item_id    (item_id),
        .key        (key),
        .status     (status),
        .out_id     (out_id),
        .out_key    (out_key),
        .fill_count (fill_count)
    );

endmodule

// ===== hw/rtl/imhq_checker.sv =====
// ----------------------------------------------------------------------------
// imhq_checker
// port-level checks on request and result timing and on reported counts
// ----------------------------------------------------------------------------
`include "indexed_min_heap_queue_core_macros.svh"

module imhq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [1:0]                        status,
    input logic [imhq_pkg::CNT_W-1:0]        fill_count
);
    import imhq_pkg::*;

    // an accepted request makes the block busy
    `IMHQ_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // result strobe lasts one cycle
    `IMHQ_ASSERT_NXT(a_done_pulse, done, !done)
    // full is only reported at capacity
    `IMHQ_ASSERT_IMP(a_full_count, done && (status == STAT_FULL), fill_count == CNT_W'(CAPACITY))
    // empty is only reported with no entries
    `IMHQ_ASSERT_IMP(a_empty_count, done && (status == STAT_EMPTY), fill_count == '0)
    // count never exceeds capacity at a result strobe
    `IMHQ_ASSERT_IMP(a_count_max, done, fill_count <= CNT_W'(CAPACITY))

endmodule

bind indexed_min_heap_queue_core imhq_checker u_chk (.*);
